>>> rtl/ugl_pkg.sv
// ----------------------------------------------------------------------------
// ugl_pkg
// types and constants shared by the utf-8 glyph lookup and width block
// ----------------------------------------------------------------------------
package ugl_pkg;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEXT = 1'b1;

  localparam int ENTRY_BASE = 8 * 4 + 16 + 8;

  typedef struct packed {
    logic        cmd;
    logic [15:0] font_addr;
    logic [7:0]  font_byte;
    logic [7:0]  text_byte;
  } in_t;

  typedef struct packed {
    logic [30:0] code_point;
    logic        found;
    logic [7:0]  glyph_width;
    logic [7:0]  glyph_height;
    logic [7:0]  offset_x;
    logic [7:0]  offset_y;
    logic [18:0] bitmap_bit_addr;
    logic [15:0] total_width;
    logic        end_of_string;
  } out_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  fw;
    logic [7:0]  fh;
    logic [7:0]  ox;
    logic [7:0]  oy;
    logic [18:0] bit_addr;
  } lk_res_t;

endpackage

>>> rtl/ugl_bitrd.sv
// ----------------------------------------------------------------------------
// ugl_bitrd
// font byte memory with a bit-serial msb-first field reader
// ----------------------------------------------------------------------------
module ugl_bitrd #(
  parameter int AW = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  logic [7:0]      wr_data,
  input  logic            start,
  input  logic [AW+2:0]   pos,
  input  logic [7:0]      len,
  output logic            done,
  output logic [31:0]     value
);

  logic [7:0]    mem [2**AW];
  logic [7:0]    rdata;
  logic [2:0]    bsel;
  logic          rv;
  logic          busy;
  logic [AW+2:0] cur_pos;
  logic [7:0]    iss_left;
  logic [7:0]    rcv_left;

  assign done = busy && (rcv_left == 8'd0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[cur_pos[AW+2:3]];
    bsel  <= cur_pos[2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rv       <= 1'b0;
      iss_left <= '0;
      rcv_left <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      rv       <= 1'b0;
      cur_pos  <= pos;
      iss_left <= len;
      rcv_left <= len;
      value    <= '0;
    end else begin
      rv <= busy && (iss_left != 8'd0);
      if (busy && iss_left != 8'd0) begin
        cur_pos  <= cur_pos + 1'b1;
        iss_left <= iss_left - 8'd1;
      end
      if (rv) begin
        value    <= {value[30:0], rdata[3'd7 - bsel]};
        rcv_left <= rcv_left - 8'd1;
      end
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/ugl_lookup.sv
// ----------------------------------------------------------------------------
// ugl_lookup
// header fetch, first and last entry checks and binary search sequencer
// ----------------------------------------------------------------------------
module ugl_lookup #(
  parameter int BW          = 19,
  parameter int SEARCH_SPAN = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [30:0]        code,
  output logic               done,
  output ugl_pkg::lk_res_t   res,
  output logic               rd_start,
  output logic [BW-1:0]      rd_pos,
  output logic [7:0]         rd_len,
  input  logic               rd_done,
  input  logic [31:0]        rd_value
);

  localparam int MW = $clog2(SEARCH_SPAN + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_HDR    = 4'd1;
  localparam logic [3:0] S_MUL1   = 4'd2;
  localparam logic [3:0] S_STRIDE = 4'd3;
  localparam logic [3:0] S_FIRST  = 4'd4;
  localparam logic [3:0] S_MUL    = 4'd5;
  localparam logic [3:0] S_POS    = 4'd6;
  localparam logic [3:0] S_PROBE  = 4'd7;
  localparam logic [3:0] S_STEP   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  localparam logic PH_LAST   = 1'b0;
  localparam logic PH_SEARCH = 1'b1;

  logic [3:0]    state;
  logic [31:0]   code_q;
  logic [2:0]    hdr_idx;
  logic          rd_pend;
  logic [7:0]    fw, fh, ox, oy, cw;
  logic [15:0]   count;
  logic [32:0]   prod;
  logic [16:0]   stride;
  logic [15:0]   idx;
  logic [15:0]   base;
  logic [MW-1:0] m;
  logic [MW-1:0] m_next;
  logic [15:0]   idx_c;
  logic [BW-1:0] pos_q;
  logic [BW-1:0] epos;
  logic [BW-1:0] epos_cw;
  logic          phase;
  logic          hit;
  logic [16:0]   mul_a;
  logic [15:0]   mul_b;

  assign m_next  = m >> 1;
  assign idx_c   = base | 16'(m_next);
  assign epos_cw = epos + BW'(cw);

  always_comb begin
    mul_a = stride;
    mul_b = idx;
    if (state == S_MUL1) begin
      mul_a = {9'd0, fw};
      mul_b = {8'd0, fh};
    end
  end

  always_comb begin
    rd_start = 1'b0;
    rd_pos   = pos_q;
    rd_len   = cw;
    case (state)
      S_HDR: begin
        rd_start = !rd_pend;
        rd_pos   = (hdr_idx == 3'd5) ? BW'(48) : BW'({hdr_idx, 3'b000});
        rd_len   = (hdr_idx == 3'd4) ? 8'd16 : 8'd8;
      end
      S_FIRST: begin
        rd_start = !rd_pend;
        rd_pos   = BW'(ugl_pkg::ENTRY_BASE);
      end
      S_PROBE: begin
        rd_start = !rd_pend;
      end
      default: begin
        rd_start = 1'b0;
      end
    endcase
  end

  assign res.hit      = hit;
  assign res.fw       = hit ? fw : 8'd0;
  assign res.fh       = fh;
  assign res.ox       = ox;
  assign res.oy       = oy;
  assign res.bit_addr = hit ? 19'(epos_cw) : 19'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (rd_start) begin
        rd_pend <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            code_q  <= {1'b0, code};
            hdr_idx <= 3'd0;
            hit     <= 1'b0;
            epos    <= '0;
            state   <= S_HDR;
          end
        end
        S_HDR: begin
          if (rd_done) begin
            rd_pend <= 1'b0;
            case (hdr_idx)
              3'd0:    fw    <= rd_value[7:0];
              3'd1:    fh    <= rd_value[7:0];
              3'd2:    ox    <= rd_value[7:0];
              3'd3:    oy    <= rd_value[7:0];
              3'd4:    count <= rd_value[15:0];
              default: cw    <= rd_value[7:0];
            endcase
            hdr_idx <= hdr_idx + 3'd1;
            if (hdr_idx == 3'd5) begin
              state <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          prod  <= mul_a * mul_b;
          state <= S_STRIDE;
        end
        S_STRIDE: begin
          stride <= prod[16:0] + {9'd0, cw};
          state  <= (count == 16'd0) ? S_DONE : S_FIRST;
        end
        S_FIRST: begin
          if (rd_done) begin
            rd_pend <= 1'b0;
            if (code_q == rd_value) begin
              hit   <= 1'b1;
              epos  <= BW'(ugl_pkg::ENTRY_BASE);
              state <= S_DONE;
            end else if (code_q > rd_value) begin
              idx   <= count - 16'd1;
              phase <= PH_LAST;
              state <= S_MUL;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_MUL: begin
          prod  <= mul_a * mul_b;
          state <= S_POS;
        end
        S_POS: begin
          pos_q <= BW'(ugl_pkg::ENTRY_BASE) + prod[BW-1:0];
          state <= S_PROBE;
        end
        S_PROBE: begin
          if (rd_done) begin
            rd_pend <= 1'b0;
            if (code_q == rd_value) begin
              hit   <= 1'b1;
              epos  <= pos_q;
              state <= S_DONE;
            end else if (phase == PH_LAST) begin
              if (code_q < rd_value) begin
                base  <= '0;
                m     <= MW'(SEARCH_SPAN);
                phase <= PH_SEARCH;
                state <= S_STEP;
              end else begin
                state <= S_DONE;
              end
            end else begin
              if (code_q > rd_value) begin
                base <= idx;
              end
              state <= S_STEP;
            end
          end
        end
        S_STEP: begin
          if (m == '0) begin
            state <= S_DONE;
          end else begin
            m <= m_next;
            if (idx_c < count) begin
              idx   <= idx_c;
              state <= S_MUL;
            end
          end
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/utf8_glyph_lookup_width_core.sv
// ----------------------------------------------------------------------------
// utf8_glyph_lookup_width_core
// utf-8 decoder with font glyph lookup and string width totals
// ----------------------------------------------------------------------------
// lookup: a lookup takes six header reads plus probes of the entry table, their
//   number bounded by SEARCH_SPAN, each a cw-bit read from the bit-serial font
//   memory reader, and each probe after the first needs a multiply step first
// throughput: one item at a time, not ready while a lookup runs or a result waits
// reset: decoder state and width total cleared; font memory is undefined
module utf8_glyph_lookup_width_core #(
  parameter int FONT_BYTES  = 65536,
  parameter int SEARCH_SPAN = 65536
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ugl_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ugl_pkg::out_t out_data
);

  localparam int AW = $clog2(FONT_BYTES);
  localparam int BW = AW + 3;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_LOOK = 2'd1;
  localparam logic [1:0] T_HOLD = 2'd2;

  logic [1:0]        tstate;
  logic [30:0]       char_accum;
  logic [2:0]        bytes_left;
  logic [15:0]       width_sum;
  ugl_pkg::out_t     res;
  logic [30:0]       acc_next;
  logic              take;
  logic              lk_start;
  logic [30:0]       lk_code;
  logic              lk_done;
  ugl_pkg::lk_res_t  lk_res;
  logic              rd_start;
  logic [BW-1:0]     rd_pos;
  logic [7:0]        rd_len;
  logic              rd_done;
  logic [31:0]       rd_value;
  logic [16:0]       sum_wide;
  logic [15:0]       sum_sat;
  logic [7:0]        b;

  assign in_ready = (tstate == T_IDLE);
  assign take     = in_valid && in_ready;
  assign b        = in_data.text_byte;
  assign acc_next = {char_accum[24:0], b[5:0]};
  assign sum_wide = {1'b0, width_sum} + {9'd0, lk_res.fw};
  assign sum_sat  = sum_wide[16] ? 16'hffff : sum_wide[15:0];

  always_comb begin
    lk_start = 1'b0;
    lk_code  = {23'd0, b};
    if (take && in_data.cmd == ugl_pkg::CMD_TEXT) begin
      if (bytes_left != 3'd0) begin
        lk_code  = acc_next;
        lk_start = (bytes_left == 3'd1);
      end else begin
        lk_start = (b != 8'd0) && !b[7];
      end
    end
  end

  ugl_bitrd #(.AW(AW)) u_bitrd (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (take && in_data.cmd == ugl_pkg::CMD_LOAD),
    .wr_addr (AW'(in_data.font_addr)),
    .wr_data (in_data.font_byte),
    .start   (rd_start),
    .pos     (rd_pos),
    .len     (rd_len),
    .done    (rd_done),
    .value   (rd_value)
  );

  ugl_lookup #(.BW(BW), .SEARCH_SPAN(SEARCH_SPAN)) u_lookup (
    .clk      (clk),
    .rst      (rst),
    .start    (lk_start),
    .code     (lk_code),
    .done     (lk_done),
    .res      (lk_res),
    .rd_start (rd_start),
    .rd_pos   (rd_pos),
    .rd_len   (rd_len),
    .rd_done  (rd_done),
    .rd_value (rd_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tstate     <= T_IDLE;
      char_accum <= '0;
      bytes_left <= '0;
      width_sum  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (tstate)
        T_IDLE: begin
          if (lk_start) begin
            res.code_point <= lk_code;
            tstate         <= T_LOOK;
          end
          if (take && in_data.cmd == ugl_pkg::CMD_TEXT) begin
            if (bytes_left != 3'd0) begin
              char_accum <= acc_next;
              bytes_left <= bytes_left - 3'd1;
            end else if (b == 8'd0) begin
              res           <= '0;
              res.total_width   <= width_sum;
              res.end_of_string <= 1'b1;
              width_sum     <= '0;
              tstate        <= T_HOLD;
            end else if (b[7:5] == 3'b110) begin
              char_accum <= {26'd0, b[4:0]};
              bytes_left <= 3'd1;
            end else if (b[7:4] == 4'b1110) begin
              char_accum <= {27'd0, b[3:0]};
              bytes_left <= 3'd2;
            end else if (b[7:3] == 5'b11110) begin
              char_accum <= {28'd0, b[2:0]};
              bytes_left <= 3'd3;
            end else if (b[7:2] == 6'b111110) begin
              char_accum <= {29'd0, b[1:0]};
              bytes_left <= 3'd4;
            end else if (b[7:1] == 7'b1111110) begin
              char_accum <= {30'd0, b[0]};
              bytes_left <= 3'd5;
            end
          end
        end
        T_LOOK: begin
          if (lk_done) begin
            res.found           <= lk_res.hit;
            res.glyph_width     <= lk_res.fw;
            res.glyph_height    <= lk_res.fh;
            res.offset_x        <= lk_res.ox;
            res.offset_y        <= lk_res.oy;
            res.bitmap_bit_addr <= lk_res.bit_addr;
            res.end_of_string   <= 1'b0;
            if (lk_res.hit) begin
              width_sum       <= sum_sat;
              res.total_width <= sum_sat;
            end else begin
              res.total_width <= width_sum;
            end
            tstate <= T_HOLD;
          end
        end
        T_HOLD: begin
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            tstate    <= T_IDLE;
          end
        end
        default: begin
          tstate <= T_IDLE;
        end
      endcase
    end
  end

  a_left_range: assert property (@(posedge clk) disable iff (rst)
    bytes_left <= 3'd5)
    else $error("continuation count out of range");

  a_eos_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.end_of_string |-> !out_data.found && out_data.code_point == '0)
    else $error("end of string result carries glyph data");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |->
      out_data.glyph_width == 8'd0 && out_data.bitmap_bit_addr == 19'd0)
    else $error("missed glyph reports width or address");

  a_busy_block: assert property (@(posedge clk) disable iff (rst)
    tstate == T_LOOK |=> !lk_done || !in_ready)
    else $error("input taken during lookup");

endmodule
